// ===== sv/rcrr_pkg.sv =====
// Shared types and default sizes for the retry credit round-robin arbiter.
// Used by rcrr_ctrl, rcrr_dp and the top level; depends on nothing else.
package rcrr_pkg;

	localparam int unsigned DEF_NUM_SOURCES     = 16;
	localparam int unsigned DEF_PRIORITY_LEVELS = 4;
	localparam int unsigned DEF_COUNT_WIDTH     = 8;

	// Fixed field widths of the stream payloads
	localparam int unsigned SRC_FIELD_W = 4;
	localparam int unsigned CLS_FIELD_W = 2;

	// Commands from the controller to the datapath, one per phase
	typedef struct packed {
		logic load;       // capture the input transaction
		logic pick_src;   // round-robin source search
		logic read_cp;    // read the class pointer of the chosen source
		logic pick_cls;   // round-robin class search, form counter index
		logic read_cnt;   // read the pending counter
		logic write_back; // update counter, flags, pointers and result
	} rcrr_cmd_t;

endpackage

// ===== sv/rcrr_ctrl.sv =====
// Sequencer for the retry credit arbiter: steps one transaction through
// the datapath phases and runs both stream handshakes. Uses rcrr_pkg.
module rcrr_ctrl
	import rcrr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	output rcrr_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_CPR,
		ST_CLS,
		ST_RD,
		ST_WB,
		ST_OUT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load       = s_tvalid;
			ST_PICK: cmd.pick_src   = 1'b1;
			ST_CPR:  cmd.read_cp    = 1'b1;
			ST_CLS:  cmd.pick_cls   = 1'b1;
			ST_RD:   cmd.read_cnt   = 1'b1;
			ST_WB:   cmd.write_back = 1'b1;
			ST_OUT:  cmd = '0;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_PICK;
				ST_PICK: state_q <= ST_CPR;
				ST_CPR:  state_q <= ST_CLS;
				ST_CLS:  state_q <= ST_RD;
				ST_RD:   state_q <= ST_WB;
				ST_WB:   state_q <= ST_OUT;
				ST_OUT:  if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/rcrr_dp.sv =====
// Datapath of the retry credit arbiter: pending counter memory, nonzero
// flags, class pointer memory, source pointer and result register.
// Driven by rcrr_cmd_t from rcrr_ctrl; uses rcrr_pkg.
module rcrr_dp
	import rcrr_pkg::*;
#(
	parameter int unsigned NUM_SOURCES     = DEF_NUM_SOURCES,
	parameter int unsigned PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
	parameter int unsigned COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rcrr_cmd_t              cmd,
	input  logic                   in_action,
	input  logic [SRC_FIELD_W-1:0] in_src_id,
	input  logic [CLS_FIELD_W-1:0] in_priority_class,
	output logic                   grant_valid,
	output logic [SRC_FIELD_W-1:0] grant_src,
	output logic [CLS_FIELD_W-1:0] grant_priority,
	output logic                   dropped
);

	localparam int unsigned SRC_W   = $clog2(NUM_SOURCES);
	localparam int unsigned CLS_W   = $clog2(PRIORITY_LEVELS);
	localparam int unsigned ENTRIES = NUM_SOURCES * PRIORITY_LEVELS;
	localparam int unsigned IDX_W   = $clog2(ENTRIES);
	localparam int unsigned SX_W    = (SRC_W > SRC_FIELD_W) ? SRC_W : SRC_FIELD_W;
	localparam int unsigned CX_W    = (CLS_W > CLS_FIELD_W) ? CLS_W : CLS_FIELD_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Captured transaction
	logic             act_q;
	logic             inr_q;
	logic [SRC_W-1:0] src_q;
	logic [CLS_W-1:0] cls_q;

	// Search and read results
	logic             found_q;
	logic [SRC_W-1:0] sel_src_q;
	logic [CLS_W-1:0] cp_rd_q;
	logic             cp_v_q;
	logic [CLS_W-1:0] sel_cls_q;
	logic [CLS_W-1:0] cls_next;
	logic [IDX_W-1:0] idx_q;
	logic [COUNT_WIDTH-1:0] rd_q;
	logic             rd_nz_q;

	// State
	logic [ENTRIES-1:0]     nz_q;
	logic [NUM_SOURCES-1:0] cp_vld_q;
	logic [SRC_W-1:0]       src_ptr_q;
	logic [COUNT_WIDTH-1:0] cnt_mem [ENTRIES];
	logic [CLS_W-1:0]       cp_mem [NUM_SOURCES];

	// Input field conversion to internal index widths
	logic [SX_W-1:0]  in_src_x;
	logic [CX_W-1:0]  in_cls_x;
	logic             in_range;

	assign in_src_x = SX_W'(in_src_id);
	assign in_cls_x = CX_W'(in_priority_class);
	assign in_range = (32'(in_src_id) < NUM_SOURCES)
		&& (32'(in_priority_class) < PRIORITY_LEVELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			inr_q <= 1'b0;
		end else if (cmd.load) begin
			act_q <= in_action;
			inr_q <= in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q <= in_src_x[SRC_W-1:0];
			cls_q <= in_cls_x[CLS_W-1:0];
		end
	end

	// Source level: busy vector and rotating priority encoder
	logic [NUM_SOURCES-1:0] busy;
	logic                   s_hit_hi;
	logic                   s_hit_lo;
	logic [SRC_W-1:0]       s_pos_hi;
	logic [SRC_W-1:0]       s_pos_lo;

	always_comb begin
		for (int s = 0; s < NUM_SOURCES; s++) begin
			busy[s] = |nz_q[s*PRIORITY_LEVELS +: PRIORITY_LEVELS];
		end
	end

	always_comb begin
		s_hit_hi = 1'b0;
		s_hit_lo = 1'b0;
		s_pos_hi = '0;
		s_pos_lo = '0;
		// Descending scan leaves the lowest set position
		for (int j = NUM_SOURCES - 1; j >= 0; j--) begin
			if (busy[j]) begin
				s_hit_lo = 1'b1;
				s_pos_lo = SRC_W'(j);
				if (j >= int'(src_ptr_q)) begin
					s_hit_hi = 1'b1;
					s_pos_hi = SRC_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.pick_src) begin
			found_q <= s_hit_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick_src) begin
			sel_src_q <= s_hit_hi ? s_pos_hi : s_pos_lo;
		end
	end

	// Class pointer memory, read with registered data
	always_ff @(posedge clk) begin
		if (cmd.read_cp) begin
			cp_rd_q <= cp_mem[sel_src_q];
			cp_v_q  <= cp_vld_q[sel_src_q];
		end
		if (cmd.write_back && act_q && found_q) begin
			cp_mem[sel_src_q] <= cls_next;
		end
	end

	// Class level: rotating priority encoder within the chosen source
	logic [CLS_W-1:0]           cls_ptr;
	logic [PRIORITY_LEVELS-1:0] row;
	logic                       c_hit_hi;
	logic [CLS_W-1:0]           c_pos_hi;
	logic [CLS_W-1:0]           c_pos_lo;
	logic [CLS_W-1:0]           cls_pick;
	logic [IDX_W-1:0]           idx_arb;
	logic [IDX_W-1:0]           idx_enq;

	assign cls_ptr = cp_v_q ? cp_rd_q : '0;

	always_comb begin
		for (int c = 0; c < PRIORITY_LEVELS; c++) begin
			row[c] = nz_q[IDX_W'(32'(sel_src_q) * PRIORITY_LEVELS + c)];
		end
	end

	always_comb begin
		c_hit_hi = 1'b0;
		c_pos_hi = '0;
		c_pos_lo = '0;
		for (int j = PRIORITY_LEVELS - 1; j >= 0; j--) begin
			if (row[j]) begin
				c_pos_lo = CLS_W'(j);
				if (j >= int'(cls_ptr)) begin
					c_hit_hi = 1'b1;
					c_pos_hi = CLS_W'(j);
				end
			end
		end
	end

	assign cls_pick = c_hit_hi ? c_pos_hi : c_pos_lo;
	assign idx_arb  = IDX_W'(32'(sel_src_q) * PRIORITY_LEVELS + 32'(cls_pick));
	assign idx_enq  = IDX_W'(32'(src_q) * PRIORITY_LEVELS + 32'(cls_q));
	assign cls_next = (sel_cls_q == CLS_W'(PRIORITY_LEVELS - 1)) ? '0 : sel_cls_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.pick_cls) begin
			sel_cls_q <= cls_pick;
			idx_q     <= act_q ? idx_arb : idx_enq;
		end
	end

	// Pending counter memory; a clear nonzero flag means the entry reads zero
	logic [COUNT_WIDTH-1:0] cnt_eff;
	logic                   cnt_sat;
	logic                   enq_wr;
	logic                   arb_wr;

	assign cnt_eff = rd_nz_q ? rd_q : '0;
	assign cnt_sat = (cnt_eff == COUNT_MAX);
	assign enq_wr  = cmd.write_back && !act_q && inr_q && !cnt_sat;
	assign arb_wr  = cmd.write_back && act_q && found_q;

	always_ff @(posedge clk) begin
		if (cmd.read_cnt) begin
			rd_q    <= cnt_mem[idx_q];
			rd_nz_q <= nz_q[idx_q];
		end
		if (enq_wr) begin
			cnt_mem[idx_q] <= cnt_eff + 1'b1;
		end else if (arb_wr) begin
			cnt_mem[idx_q] <= cnt_eff - 1'b1;
		end
	end

	// Flags, pointers and the result register
	logic [SRC_W-1:0] src_next;
	logic [SX_W-1:0]  gsrc_x;
	logic [CX_W-1:0]  gcls_x;

	assign src_next = (sel_src_q == SRC_W'(NUM_SOURCES - 1)) ? '0 : sel_src_q + 1'b1;
	assign gsrc_x   = SX_W'(sel_src_q);
	assign gcls_x   = CX_W'(sel_cls_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q           <= '0;
			cp_vld_q       <= '0;
			src_ptr_q      <= '0;
			grant_valid    <= 1'b0;
			grant_src      <= '0;
			grant_priority <= '0;
			dropped        <= 1'b0;
		end else if (cmd.write_back) begin
			grant_valid    <= arb_wr;
			grant_src      <= arb_wr ? gsrc_x[SRC_FIELD_W-1:0] : '0;
			grant_priority <= arb_wr ? gcls_x[CLS_FIELD_W-1:0] : '0;
			dropped        <= !act_q && inr_q && cnt_sat;
			if (enq_wr) begin
				nz_q[idx_q] <= 1'b1;
			end
			if (arb_wr) begin
				nz_q[idx_q]          <= (cnt_eff != COUNT_WIDTH'(1));
				cp_vld_q[sel_src_q]  <= 1'b1;
				src_ptr_q            <= src_next;
			end
		end
	end

endmodule

// ===== sv/retry_credit_two_level_round_robin.sv =====
// Retry credit arbiter with two round-robin levels. Each transaction on the
// slave side either enqueues one pending retry for a source and class
// (s_tuser = 0) or asks for one grant (s_tuser = 1); exactly one result
// transaction follows on the master side. A grant goes to the next busy
// source after the last winner and, inside it, to the next busy class after
// that source's last served class. Enqueues to a saturated counter report
// dropped. One transaction is in flight at a time: after acceptance the
// phases run in order (source search, class pointer read, class search,
// counter read, write-back) before the result is valid, and a new
// transaction is taken the cycle after the result is consumed. The counters
// live in a single-port memory whose read and write-back are separate
// phases. No clearing pass is needed after reset.
module retry_credit_two_level_round_robin
	import rcrr_pkg::*;
#(
	parameter int unsigned NUM_SOURCES     = DEF_NUM_SOURCES,
	parameter int unsigned PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
	parameter int unsigned COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [3:0] src_id, [5:4] priority_class, [7:6] zero
	input  logic       s_tuser,  // action: 0 enqueue, 1 arbitrate
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] grant_valid, [4:1] grant_src,
	                             // [6:5] grant_priority, [7] dropped
);

	rcrr_cmd_t              cmd;
	logic                   grant_valid;
	logic [SRC_FIELD_W-1:0] grant_src;
	logic [CLS_FIELD_W-1:0] grant_priority;
	logic                   dropped;

	rcrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rcrr_dp #(
		.NUM_SOURCES     (NUM_SOURCES),
		.PRIORITY_LEVELS (PRIORITY_LEVELS),
		.COUNT_WIDTH     (COUNT_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.in_action         (s_tuser),
		.in_src_id         (s_tdata[3:0]),
		.in_priority_class (s_tdata[5:4]),
		.grant_valid       (grant_valid),
		.grant_src         (grant_src),
		.grant_priority    (grant_priority),
		.dropped           (dropped)
	);

	assign m_tdata = {dropped, grant_priority, grant_src, grant_valid};

endmodule
